/* rtl/core/cdd_pkg.sv */
`default_nettype none

package cdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int ORDER_W = 2;
    localparam int COUNT_W = 22;
    localparam int NUM_W   = 23;

    localparam int YEAR_LIMIT_DEFAULT = 9999;

    // Floor division by 25 as a multiply by 5243 and a shift by 17.
    localparam int RECIP_25    = 5243;
    localparam int RECIP_SHIFT = 17;

    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd2;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_APR = 4'd4;
    localparam logic [MONTH_W-1:0] MONTH_JUN = 4'd6;
    localparam logic [MONTH_W-1:0] MONTH_SEP = 4'd9;
    localparam logic [MONTH_W-1:0] MONTH_NOV = 4'd11;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic             valid;
    } day_num_t;

    function automatic logic [8:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd2:    r = 9'd31;
                4'd3:    r = 9'd59;
                4'd4:    r = 9'd90;
                4'd5:    r = 9'd120;
                4'd6:    r = 9'd151;
                4'd7:    r = 9'd181;
                4'd8:    r = 9'd212;
                4'd9:    r = 9'd243;
                4'd10:   r = 9'd273;
                4'd11:   r = 9'd304;
                4'd12:   r = 9'd334;
                default: r = 9'd0;
            endcase
            return r;
        end
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        begin
            if (m == MONTH_FEB) begin
                r = leap ? 5'd29 : 5'd28;
            end else if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP ||
                         m == MONTH_NOV) begin
                r = 5'd30;
            end else begin
                r = 5'd31;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cdd_day_number.sv */
`default_nettype none

module cdd_day_number #(
    parameter int YEAR_LIMIT = cdd_pkg::YEAR_LIMIT_DEFAULT
) (
    input  wire logic              aclk,
    input  wire logic              enable,
    input  wire cdd_pkg::date_t    date_in,
    output cdd_pkg::day_num_t      result
);

    localparam logic [15:0] LIMIT = 16'(YEAR_LIMIT);
    localparam int SH = cdd_pkg::RECIP_SHIFT;

    // First stage: constant products and quotients.
    logic [cdd_pkg::YEAR_W-1:0]  year_reg;
    logic [cdd_pkg::MONTH_W-1:0] month_reg;
    logic [cdd_pkg::DAY_W-1:0]   day_reg;
    logic [cdd_pkg::NUM_W-1:0]   y365_reg;
    logic [12:0]                 q4_reg;
    logic [7:0]                  q100_reg;
    logic [7:0]                  q400_reg;
    logic [7:0]                  ydiv100_reg;
    logic                        year_ok_reg;

    logic [14:0] sum_a, sum_b, sum_c;
    logic [12:0] qb;
    logic [10:0] qc;
    logic [11:0] qy;
    logic [25:0] pb, pc, py;

    always_comb begin
        sum_a = {1'b0, date_in.year} + 15'd3;
        sum_b = {1'b0, date_in.year} + 15'd99;
        sum_c = {1'b0, date_in.year} + 15'd399;
        qb    = 13'(sum_b >> 2);
        qc    = 11'(sum_c >> 4);
        qy    = 12'(date_in.year >> 2);
        pb    = {13'b0, qb} * 26'(cdd_pkg::RECIP_25);
        pc    = {15'b0, qc} * 26'(cdd_pkg::RECIP_25);
        py    = {14'b0, qy} * 26'(cdd_pkg::RECIP_25);
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            year_reg    <= date_in.year;
            month_reg   <= date_in.month;
            day_reg     <= date_in.day;
            y365_reg    <= cdd_pkg::NUM_W'(date_in.year) * cdd_pkg::NUM_W'(365);
            q4_reg      <= 13'(sum_a >> 2);
            q100_reg    <= 8'(pb >> SH);
            q400_reg    <= 8'(pc >> SH);
            ydiv100_reg <= 8'(py >> SH);
            year_ok_reg <= ({2'b0, date_in.year} <= LIMIT);
        end
    end

    // Second stage: leap test, validity and the day number itself.
    logic             div100, div400, leap, month_ok, adj;
    logic [4:0]       mlen;
    logic [23:0]      num_sum;
    logic [14:0]      hundreds;

    always_comb begin
        hundreds = 15'(ydiv100_reg) * 15'd100;
        div100   = (hundreds == {1'b0, year_reg});
        div400   = div100 && (year_reg[3:0] == 4'd0);
        leap     = ((year_reg[1:0] == 2'd0) && !div100) || div400;
        mlen     = cdd_pkg::month_length(month_reg, leap);
        month_ok = month_reg inside {[4'd1:4'd12]};
        adj      = (month_reg > cdd_pkg::MONTH_FEB) && leap;
        num_sum  = {1'b0, y365_reg} + 24'(q4_reg) + 24'(q400_reg)
                 + 24'(cdd_pkg::days_before_month(month_reg)) + 24'(adj)
                 + 24'(day_reg) - 24'(q100_reg) - 24'd1;
    end

    always_ff @(posedge aclk) begin
        if (enable) begin
            result.num   <= cdd_pkg::NUM_W'(num_sum);
            result.valid <= month_ok && year_ok_reg && (day_reg != 5'd0) &&
                            (day_reg <= mlen);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/calendar_date_difference.sv */
// Gregorian date difference.
// The input channel (s_valid, s_ready) carries two dates as day, month and
// year. The result channel (m_valid, m_ready) gives their order, the
// absolute number of days between them and a flag that both are valid.
// When either date is invalid the count is zero and the flag is low, while
// the order still compares the raw fields by year, month and day.
// The block is a four-register pipeline: input register, a stage of constant
// multiplies for the leap-day quotients, a stage that sums each day number,
// and the result register. One item can be taken on every cycle while the
// result channel does not hold the pipeline.
// When the receiver holds m_ready low with a result waiting, the whole
// pipeline holds and s_ready goes low in the same cycle; it rises again as
// soon as the waiting result is taken.
// Synchronous reset empties every stage; no result is shown after reset
// until a new item has come through.
`default_nettype none

module calendar_date_difference #(
    parameter int YEAR_LIMIT = cdd_pkg::YEAR_LIMIT_DEFAULT
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [cdd_pkg::DAY_W-1:0]     s_first_day,
    input  wire logic [cdd_pkg::MONTH_W-1:0]   s_first_month,
    input  wire logic [cdd_pkg::YEAR_W-1:0]    s_first_year,
    input  wire logic [cdd_pkg::DAY_W-1:0]     s_second_day,
    input  wire logic [cdd_pkg::MONTH_W-1:0]   s_second_month,
    input  wire logic [cdd_pkg::YEAR_W-1:0]    s_second_year,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [cdd_pkg::ORDER_W-1:0]        m_order,
    output logic [cdd_pkg::COUNT_W-1:0]        m_day_count,
    output logic                               m_both_valid
);

    localparam logic [cdd_pkg::NUM_W-1:0] COUNT_MAX =
        cdd_pkg::NUM_W'({cdd_pkg::COUNT_W{1'b1}});

    logic advance;
    logic in_valid_reg, st1_valid_reg, st2_valid_reg, m_valid_reg;

    cdd_pkg::date_t first_reg, second_reg;
    logic [cdd_pkg::ORDER_W-1:0] order_next, st1_order_reg, st2_order_reg, m_order_reg;
    logic [cdd_pkg::COUNT_W-1:0] count_next, m_count_reg;
    logic                        both_next, m_both_reg;
    cdd_pkg::day_num_t           first_num, second_num;
    logic [cdd_pkg::NUM_W-1:0]   diff;
    logic [22:0]                 key_first, key_second;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else if (advance) begin
            in_valid_reg  <= s_valid;
            st1_valid_reg <= in_valid_reg;
            st2_valid_reg <= st1_valid_reg;
            m_valid_reg   <= st2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            first_reg     <= '{day: s_first_day, month: s_first_month, year: s_first_year};
            second_reg    <= '{day: s_second_day, month: s_second_month,
                               year: s_second_year};
            st1_order_reg <= order_next;
            st2_order_reg <= st1_order_reg;
            m_order_reg   <= st2_order_reg;
            m_count_reg   <= count_next;
            m_both_reg    <= both_next;
        end
    end

    always_comb begin
        key_first  = {first_reg.year, first_reg.month, first_reg.day};
        key_second = {second_reg.year, second_reg.month, second_reg.day};
        if (key_first == key_second) begin
            order_next = cdd_pkg::ORDER_EQUAL;
        end else if (key_first > key_second) begin
            order_next = cdd_pkg::ORDER_LATER;
        end else begin
            order_next = cdd_pkg::ORDER_EARLIER;
        end
    end

    cdd_day_number #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) u_first (
        .aclk   (aclk),
        .enable (advance),
        .date_in(first_reg),
        .result (first_num)
    );

    cdd_day_number #(
        .YEAR_LIMIT(YEAR_LIMIT)
    ) u_second (
        .aclk   (aclk),
        .enable (advance),
        .date_in(second_reg),
        .result (second_num)
    );

    always_comb begin
        both_next = first_num.valid && second_num.valid;
        diff = (first_num.num >= second_num.num) ? (first_num.num - second_num.num)
                                                 : (second_num.num - first_num.num);
        if (!both_next) begin
            count_next = '0;
        end else if (diff > COUNT_MAX) begin
            count_next = '1;
        end else begin
            count_next = cdd_pkg::COUNT_W'(diff);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_order      = m_order_reg;
    assign m_day_count  = m_count_reg;
    assign m_both_valid = m_both_reg;

    // An invalid pair never carries a count.
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_both_valid |-> m_day_count == '0)
        else $error("invalid date pair with nonzero count");

    // Equal valid dates are zero days apart, distinct ones are not.
    a_equal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_both_valid && m_order == cdd_pkg::ORDER_EQUAL |-> m_day_count == '0)
        else $error("equal dates with nonzero count");

    a_distinct_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_both_valid && m_order != cdd_pkg::ORDER_EQUAL |-> m_day_count != '0)
        else $error("distinct valid dates with zero count");

    a_order_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_order == cdd_pkg::ORDER_EQUAL || m_order == cdd_pkg::ORDER_LATER ||
                     m_order == cdd_pkg::ORDER_EARLIER))
        else $error("order code out of range");

    // A stalled pipeline takes no new item.
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cdd_pkg::date_t first;
        cdd_pkg::date_t second;
    } date_pair_t;

    typedef struct packed {
        logic [cdd_pkg::ORDER_W-1:0] order;
        logic [cdd_pkg::COUNT_W-1:0] day_count;
        logic                        both_valid;
    } span_t;

    localparam int unsigned LAST_YEAR   = cdd_pkg::YEAR_LIMIT_DEFAULT;
    localparam int unsigned TOP_YEAR    = (1 << cdd_pkg::YEAR_W) - 1;
    localparam int unsigned COUNT_CEIL  = (1 << cdd_pkg::COUNT_W) - 1;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          SETTLE      = 12;
    localparam int          HOLD_CYCLES = 80;
    localparam int          MAX_REPORTS = 10;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [cdd_pkg::DAY_W-1:0]    s_first_day;
    logic [cdd_pkg::MONTH_W-1:0]  s_first_month;
    logic [cdd_pkg::YEAR_W-1:0]   s_first_year;
    logic [cdd_pkg::DAY_W-1:0]    s_second_day;
    logic [cdd_pkg::MONTH_W-1:0]  s_second_month;
    logic [cdd_pkg::YEAR_W-1:0]   s_second_year;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [cdd_pkg::ORDER_W-1:0]  m_order;
    logic [cdd_pkg::COUNT_W-1:0]  m_day_count;
    logic                         m_both_valid;

    date_pair_t pending_pairs[$];
    span_t      expected_spans[$];
    date_pair_t offered_pair = '0;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    logic hold_go          = 1'b0;
    int hold_left          = 0;
    int cycle_cnt          = 0;
    int fault_cnt          = 0;
    int transfer_cnt       = 0;
    int valid_cnt          = 0;
    int result_cnt         = 0;
    int stall_cycles       = 0;

    assign s_first_day    = offered_pair.first.day;
    assign s_first_month  = offered_pair.first.month;
    assign s_first_year   = offered_pair.first.year;
    assign s_second_day   = offered_pair.second.day;
    assign s_second_month = offered_pair.second.month;
    assign s_second_year  = offered_pair.second.year;

    calendar_date_difference u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_day    (s_first_day),
        .s_first_month  (s_first_month),
        .s_first_year   (s_first_year),
        .s_second_day   (s_second_day),
        .s_second_month (s_second_month),
        .s_second_year  (s_second_year),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_order        (m_order),
        .m_day_count    (m_day_count),
        .m_both_valid   (m_both_valid)
    );

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
        if (m == cdd_pkg::MONTH_FEB) begin
            return leap_year(y) ? 29 : 28;
        end
        if (m == cdd_pkg::MONTH_APR || m == cdd_pkg::MONTH_JUN ||
            m == cdd_pkg::MONTH_SEP || m == cdd_pkg::MONTH_NOV) begin
            return 30;
        end
        return 31;
    endfunction

    function automatic bit date_ok(input cdd_pkg::date_t dt);
        if (dt.month < 1 || dt.month > 12) begin
            return 1'b0;
        end
        if (dt.year > LAST_YEAR) begin
            return 1'b0;
        end
        return dt.day >= 1 && dt.day <= month_days(dt.month, dt.year);
    endfunction

    // Days elapsed since the first day of year zero, which counts as a leap year.
    function automatic int unsigned day_ordinal(input cdd_pkg::date_t dt);
        int unsigned y;
        int unsigned n;
        y = dt.year;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        for (int unsigned k = 1; k < dt.month; k++) begin
            n += month_days(k, y);
        end
        return n + dt.day - 1;
    endfunction

    function automatic span_t predict_span(input date_pair_t p);
        span_t       r;
        int unsigned a;
        int unsigned b;
        int unsigned gap;
        if (p.first == p.second) begin
            r.order = cdd_pkg::ORDER_EQUAL;
        end else if ({p.first.year, p.first.month, p.first.day} >
                     {p.second.year, p.second.month, p.second.day}) begin
            r.order = cdd_pkg::ORDER_LATER;
        end else begin
            r.order = cdd_pkg::ORDER_EARLIER;
        end
        r.both_valid = date_ok(p.first) && date_ok(p.second);
        r.day_count  = '0;
        if (r.both_valid) begin
            a   = day_ordinal(p.first);
            b   = day_ordinal(p.second);
            gap = (a >= b) ? a - b : b - a;
            if (gap > COUNT_CEIL) begin
                gap = COUNT_CEIL;
            end
            r.day_count = gap[cdd_pkg::COUNT_W-1:0];
        end
        return r;
    endfunction

    function automatic cdd_pkg::date_t any_valid_date();
        cdd_pkg::date_t dt;
        if ($urandom_range(4) == 0) begin
            case ($urandom_range(10))
                0:       dt.year = 14'd0;
                1:       dt.year = 14'd1;
                2:       dt.year = 14'd4;
                3:       dt.year = 14'd100;
                4:       dt.year = 14'd400;
                5:       dt.year = 14'd1600;
                6:       dt.year = 14'd1900;
                7:       dt.year = 14'd2000;
                8:       dt.year = 14'd2100;
                9:       dt.year = 14'd9996;
                default: dt.year = 14'(LAST_YEAR);
            endcase
        end else begin
            dt.year = 14'($urandom_range(LAST_YEAR));
        end
        dt.month = 4'($urandom_range(1, 12));
        if ($urandom_range(3) == 0) begin
            dt.day = 5'(month_days(dt.month, dt.year));
        end else begin
            dt.day = 5'($urandom_range(1, month_days(dt.month, dt.year)));
        end
        return dt;
    endfunction

    function automatic cdd_pkg::date_t spoil_date(input cdd_pkg::date_t dt);
        case ($urandom_range(4))
            0: begin
                dt.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(13, 15));
            end
            1: begin
                dt.day = 5'd0;
            end
            2: begin
                if (month_days(dt.month, dt.year) < 31) begin
                    dt.day = 5'($urandom_range(month_days(dt.month, dt.year) + 1, 31));
                end else begin
                    dt.day = 5'd0;
                end
            end
            3: begin
                dt.year = 14'($urandom_range(LAST_YEAR + 1, TOP_YEAR));
            end
            default: begin
                dt.day   = 5'($urandom);
                dt.month = 4'($urandom);
                dt.year  = 14'($urandom);
            end
        endcase
        return dt;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t     p;
        cdd_pkg::date_t keep;
        int unsigned    sel;
        p.first = any_valid_date();
        sel = $urandom_range(99);
        if (sel < 10) begin
            p.second = p.first;
        end else if (sel < 30) begin
            p.second       = p.first;
            p.second.month = 4'($urandom_range(1, 12));
            p.second.day   = 5'($urandom_range(1, month_days(p.second.month, p.second.year)));
        end else begin
            p.second = any_valid_date();
        end
        sel = $urandom_range(99);
        if (sel < 12) begin
            p.first = spoil_date(p.first);
        end else if (sel < 24) begin
            p.second = spoil_date(p.second);
        end else if (sel < 28) begin
            p.first  = spoil_date(p.first);
            p.second = spoil_date(p.second);
        end
        if ($urandom_range(1)) begin
            keep     = p.first;
            p.first  = p.second;
            p.second = keep;
        end
        return p;
    endfunction

    task automatic offer(input int unsigned d1, input int unsigned m1, input int unsigned y1,
                         input int unsigned d2, input int unsigned m2, input int unsigned y2);
        date_pair_t p;
        p.first.day    = 5'(d1);
        p.first.month  = 4'(m1);
        p.first.year   = 14'(y1);
        p.second.day   = 5'(d2);
        p.second.month = 4'(m2);
        p.second.year  = 14'(y2);
        pending_pairs.push_back(p);
    endtask

    task automatic note_fault(input string msg);
        fault_cnt++;
        if (fault_cnt <= MAX_REPORTS) begin
            $display("mismatch: %s", msg);
        end
    endtask

    task automatic wait_idle();
        while (pending_pairs.size() != 0 || s_valid || expected_spans.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
        @(negedge aclk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) begin
            pending_pairs.push_back(random_pair());
        end
        wait_idle();
    endtask

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles without finishing", cycle_cnt);
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_spans.push_back(predict_span(offered_pair));
                transfer_cnt++;
                if (expected_spans[$].both_valid) begin
                    valid_cnt++;
                end
            end
            if (s_valid && !s_ready) begin
                stall_cycles++;
            end
            if (!s_valid || s_ready) begin
                if (pending_pairs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    offered_pair <= pending_pairs.pop_front();
                    s_valid      <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_go) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge aclk) begin : result_monitor
        span_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_spans.size() == 0) begin
                    note_fault($sformatf("result with no transfer pending: order %0d count %0d valid %0d",
                                         m_order, m_day_count, m_both_valid));
                end else begin
                    want = expected_spans.pop_front();
                    result_cnt++;
                    if (m_order !== want.order || m_day_count !== want.day_count ||
                        m_both_valid !== want.both_valid) begin
                        note_fault($sformatf({"result %0d: expected order %0d count %0d valid %0d, ",
                                              "got order %0d count %0d valid %0d"},
                                             result_cnt, want.order, want.day_count,
                                             want.both_valid, m_order, m_day_count,
                                             m_both_valid));
                    end
                end
            end
            m_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        offer(1, 1, 0, 31, 12, 9999);
        offer(31, 12, 9999, 1, 1, 0);
        offer(29, 2, 2000, 29, 2, 2000);
        offer(29, 2, 1900, 1, 3, 1900);
        offer(29, 2, 2000, 1, 3, 2000);
        offer(29, 2, 2004, 28, 2, 2003);
        offer(29, 2, 0, 1, 3, 0);
        offer(29, 2, 400, 28, 2, 100);
        offer(29, 2, 100, 1, 1, 100);
        offer(30, 2, 2024, 1, 1, 2024);
        offer(31, 1, 2023, 1, 2, 2023);
        offer(31, 12, 9999, 30, 12, 9999);
        offer(15, 0, 2020, 15, 6, 2020);
        offer(1, 13, 2020, 1, 12, 2020);
        offer(31, 15, 16383, 1, 1, 1);
        offer(0, 5, 1999, 1, 5, 1999);
        offer(31, 4, 2010, 30, 4, 2010);
        offer(1, 1, 10000, 31, 12, 9999);
        offer(12, 7, 3000, 12, 7, 3000);
        offer(31, 15, 16383, 31, 15, 16383);
        offer(0, 0, 0, 0, 0, 0);
        offer(1, 3, 1600, 28, 2, 1700);
        wait_idle();

        run_phase(150, 0, 0);
        run_phase(150, 63, 0);
        run_phase(150, 0, 63);
        run_phase(150, 37, 37);

        // The receiver holds off for a long stretch while the sender keeps a
        // transfer on offer every cycle, so the pipeline fills and stalls.
        @(negedge aclk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_go            = 1'b1;
        repeat (40) begin
            pending_pairs.push_back(random_pair());
        end
        @(negedge aclk);
        hold_go = 1'b0;
        wait_idle();

        repeat (SETTLE) @(negedge aclk);
        $display("checked %0d results from %0d transfers, %0d of them with both dates valid",
                 result_cnt, transfer_cnt, valid_cnt);
        $display("input was held back for %0d cycles by the result channel", stall_cycles);
        if (fault_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches in total", fault_cnt);
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
